// ===== design/wblur_pkg.sv =====
package wblur_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W         = 24;
    localparam int SUM_W         = 14;
    localparam int CW_W          = 6;
    localparam int DIV_W         = 7;

    localparam logic [1:0] REG_BLUR   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic start_div;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic interior;
        logic div_last;
    } sts_t;

endpackage

// ===== design/wblur_ctrl.sv =====
module wblur_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  wblur_pkg::sts_t   sts,
    output wblur_pkg::cmd_t   cmd
);

    wblur_pkg::state_t state_reg;
    wblur_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wblur_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        unique case (state_reg)
            wblur_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = wblur_pkg::ST_READ;
                end
            end
            wblur_pkg::ST_READ:
            begin
                // line store data now registered; decide on a result
                if (sts.interior)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = wblur_pkg::ST_DIV;
                end
                else
                begin
                    state_next = wblur_pkg::ST_IDLE;
                end
            end
            wblur_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = wblur_pkg::ST_OUT;
                end
            end
            wblur_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = wblur_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wblur_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/wblur_dp.sv =====
module wblur_dp
#(
    parameter int MAX_WIDTH = wblur_pkg::MAX_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wblur_pkg::cmd_t      cmd,
    output wblur_pkg::sts_t      sts,
    input  logic [7:0]           in_red,
    input  logic [7:0]           in_green,
    input  logic [7:0]           in_blue,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic [7:0]           out_red,
    output logic [7:0]           out_green,
    output logic [7:0]           out_blue,
    output logic [10:0]          center_col,
    output logic [15:0]          center_row,
    output logic                 frame_done
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int QS = 9;

    logic [2*wblur_pkg::PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*wblur_pkg::PIX_W-1:0] ls_reg;

    logic [3:0]  blur_reg;
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [CW-1:0] col_reg;
    logic [15:0] row_reg;

    logic [wblur_pkg::PIX_W-1:0] win_reg [6];
    logic [wblur_pkg::PIX_W-1:0] px_reg;
    logic [CW-1:0] colc_reg;
    logic [15:0] rowc_reg;

    logic [CW-1:0] eff_w;
    logic [15:0]   eff_h;
    logic [CW-1:0] col_use;
    logic [15:0]   row_use;
    logic [AW-1:0] addr;

    logic [wblur_pkg::SUM_W+QS-1:0] rem_reg [3];
    logic [QS-1:0]  q_reg [3];
    logic [3:0]     step_reg;
    logic [wblur_pkg::DIV_W-1:0] div_reg;
    logic [7:0]     res [3];
    logic [10:0]    ccol_reg;
    logic [15:0]    crow_reg;
    logic           done_reg;

    logic [3:0] amt;
    logic [wblur_pkg::CW_W-1:0] cwt;
    logic [wblur_pkg::PIX_W-1:0] cur0, cur1;

    logic sts_wr;
    logic rd_reg;

    always_comb
    begin
        if (width_reg < 12'd3)
        begin
            eff_w = CW'(3);
        end
        else if ({{(CW > 12 ? CW - 12 : 0){1'b0}}, width_reg} > (CW > 12 ? CW : 12)'(MAX_WIDTH))
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CW'(width_reg);
        end
        eff_h   = (height_reg < 16'd3) ? 16'd3 : height_reg;
        col_use = (col_reg >= eff_w) ? '0 : col_reg;
        row_use = (row_reg >= eff_h) ? '0 : row_reg;
        addr    = AW'(col_use);
        amt     = (blur_reg > 4'd10) ? 4'd10 : blur_reg;
        cwt     = wblur_pkg::CW_W'(wblur_pkg::CW_W'(4'd11 - amt) * wblur_pkg::CW_W'(5));
        cur0    = ls_reg[2*wblur_pkg::PIX_W-1:wblur_pkg::PIX_W];
        cur1    = ls_reg[wblur_pkg::PIX_W-1:0];
    end

    // line store: read on take, written in the read cycle
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ls_reg <= mem[addr];
        end
        if (sts_wr)
        begin
            mem[AW'(colc_reg)] <= {cur1, px_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
        end
        else
        begin
            rd_reg <= cmd.take;
        end
    end
    assign sts_wr = rd_reg;

    assign sts.interior = (colc_reg >= CW'(2)) && (rowc_reg >= 16'd2);
    assign sts.div_last = (step_reg == 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_reg   <= 4'd0;
            width_reg  <= 12'd640;
            height_reg <= 16'd480;
            col_reg    <= '0;
            row_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    wblur_pkg::REG_BLUR:
                    begin
                        blur_reg <= cfg_data[3:0];
                    end
                    wblur_pkg::REG_WIDTH:
                    begin
                        width_reg <= cfg_data[11:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    wblur_pkg::REG_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.take)
            begin
                // advance raster position
                if (col_use + CW'(1) >= eff_w)
                begin
                    col_reg <= '0;
                    row_reg <= (row_use + 16'd1 >= eff_h) ? 16'd0 : row_use + 16'd1;
                end
                else
                begin
                    col_reg <= col_use + CW'(1);
                    row_reg <= row_use;
                end
            end
            if (rd_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= cur0;
                win_reg[4] <= cur1;
                win_reg[5] <= px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            px_reg   <= {in_red, in_green, in_blue};
            colc_reg <= col_use;
            rowc_reg <= row_use;
        end
    end

    // window sums, then restoring division one quotient bit per cycle
    logic [wblur_pkg::SUM_W-1:0] sum [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = wblur_pkg::SUM_W'(win_reg[0][16-8*k +: 8])
                   + wblur_pkg::SUM_W'(win_reg[1][16-8*k +: 8])
                   + wblur_pkg::SUM_W'(win_reg[2][16-8*k +: 8])
                   + wblur_pkg::SUM_W'(win_reg[3][16-8*k +: 8])
                   + wblur_pkg::SUM_W'(win_reg[4][16-8*k +: 8]) * wblur_pkg::SUM_W'(cwt)
                   + wblur_pkg::SUM_W'(win_reg[5][16-8*k +: 8])
                   + wblur_pkg::SUM_W'(cur0[16-8*k +: 8])
                   + wblur_pkg::SUM_W'(cur1[16-8*k +: 8])
                   + wblur_pkg::SUM_W'(px_reg[16-8*k +: 8]);
        end
    end

    // window is shifted in the same edge as start_div, so sums use pre-shift
    // columns 0..5 as left/center positions and cur/px as the right column
    logic [wblur_pkg::SUM_W+QS-1:0] trial [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = rem_reg[k] - ({(wblur_pkg::SUM_W+QS-wblur_pkg::DIV_W)'(0), div_reg}
                       << step_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            div_reg  <= wblur_pkg::DIV_W'(cwt) + wblur_pkg::DIV_W'(8);
            step_reg <= 4'(QS - 1);
            ccol_reg <= 11'(colc_reg - CW'(1));
            crow_reg <= rowc_reg - 16'd1;
            done_reg <= (colc_reg == eff_w - CW'(1)) && (rowc_reg == eff_h - 16'd1);
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= (wblur_pkg::SUM_W+QS)'(sum[k]);
                q_reg[k]   <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!trial[k][wblur_pkg::SUM_W+QS-1])
                begin
                    rem_reg[k]        <= trial[k];
                    q_reg[k][step_reg] <= 1'b1;
                end
            end
            step_reg <= step_reg - 4'd1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            res[k] = q_reg[k][8] ? 8'hFF : q_reg[k][7:0];
        end
    end

    assign out_red    = res[0];
    assign out_green  = res[1];
    assign out_blue   = res[2];
    assign center_col = ccol_reg;
    assign center_row = crow_reg;
    assign frame_done = done_reg;

endmodule

// ===== design/weighted_3x3_blur_core.sv =====
// A pixel that yields no result passes through the idle and line store read states only;
// one that completes an interior window goes on through the 9-step divide and then waits
// in the output state, where out_valid is high, until out_stall is low.
// A new pixel is taken only in the idle state, once the previous one has left, so an
// output stall holds the input too; the bit-serial dividers run for the three channels.
// Reset: counters and window clear, registers return to 0/640/480; line store
// contents are undefined until written.
module weighted_3x3_blur_core
#(
    parameter int MAX_WIDTH = wblur_pkg::MAX_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   in_red,
    input  logic [7:0]   in_green,
    input  logic [7:0]   in_blue,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   out_red,
    output logic [7:0]   out_green,
    output logic [7:0]   out_blue,
    output logic [10:0]  center_col,
    output logic [15:0]  center_row,
    output logic         frame_done,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    wblur_pkg::cmd_t cmd;
    wblur_pkg::sts_t sts;

    // configuration is always taken; writes must arrive only while idle, which the block itself does not enforce
    assign cfg_ready = 1'b1;

    wblur_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    wblur_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .center_col (center_col),
        .center_row (center_row),
        .frame_done (frame_done)
    );

endmodule
